FILE: rtl/i2cm_pkg.sv
// Shared types and constants of the I2C master bit engine.
// No dependencies; i2c_master_bit_engine and i2cm_seq use it by scoped name.
package i2cm_pkg;

	localparam int unsigned HP_W          = 16;
	localparam int unsigned COUNT_W_DEF   = 16;
	localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd20;
	localparam logic [7:0] BIT_MSB        = 8'h80;
	localparam logic [3:0] LAST_DATA_BIT  = 4'd8;

	// command codes on the op field; the codes above OP_READ mean nothing
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_START = 3'd1,
		ST_STOP  = 3'd2,
		ST_WRITE = 3'd3,
		ST_READ  = 3'd4
	} st_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       nack_seen;
		logic       rejected;
	} res_t;

endpackage

FILE: rtl/i2cm_ifs.sv
// Handshake channels of the I2C master bit engine: command tick in, bus result out.
// No dependencies.
interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, op, tx_byte, send_ack, sda_in, input ready);
	modport sink   (input valid, op, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       nack_seen;
	logic       rejected;

	modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		nack_seen, rejected, input ready);
	modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		nack_seen, rejected, output ready);
endinterface

FILE: rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: handshake, half-period register, result register.
// Depends on i2cm_pkg, i2cm_ifs (i2cm_cmd_if, i2cm_res_if) and i2cm_seq.

// Each transaction on cmd is one timing tick of the bus and may carry a command:
// start, stop, write byte (MSB first, then the slave's ack is sampled into nack_seen)
// or read byte (eight bits sampled at the end of each SCL-high phase, then ack or
// nack driven). Every SCL/SDA phase holds for half_period ticks (0 acts as 1, and
// values beyond the tick counter saturate); the accepting tick is the first tick of
// the first phase. A command that arrives while a sequence runs is dropped and
// flagged in rejected. Each cmd transaction produces exactly one res transaction.
// Throughput is one tick per clock cycle: the sequencer state and the output register
// both load at the accepting edge, so the result is offered on res in the next cycle.
// cmd.ready drops only while that output register holds a result that res has not
// taken. Write half_period through cfg_we/cfg_wdata only while no tick is in flight.
module i2c_master_bit_engine #(
	parameter int unsigned COUNT_WIDTH = i2cm_pkg::COUNT_W_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	i2cm_cmd_if.sink                  cmd,
	i2cm_res_if.source                res,
	input  logic                      cfg_we,
	input  logic [i2cm_pkg::HP_W-1:0] cfg_wdata
);

	logic [i2cm_pkg::HP_W-1:0] half_period_q;
	logic                      res_valid_q;
	i2cm_pkg::res_t            res_nxt;
	i2cm_pkg::res_t            res_q;
	logic                      accept;

	// hold the tick back only while a finished result still waits downstream
	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			half_period_q <= i2cm_pkg::HALF_PERIOD_RESET;
		else if (cfg_we)
			half_period_q <= cfg_wdata;
	end

	i2cm_seq #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (accept),
		.op          (cmd.op),
		.tx_byte     (cmd.tx_byte),
		.send_ack    (cmd.send_ack),
		.sda_in      (cmd.sda_in),
		.half_period (half_period_q),
		.res_nxt     (res_nxt)
	);

	// result valid: set on every accepted tick, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (accept)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	// result payload: load with the tick's outcome
	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_nxt;
	end

	assign res.valid     = res_valid_q;
	assign res.scl_level = res_q.scl_level;
	assign res.sda_level = res_q.sda_level;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.rx_byte   = res_q.rx_byte;
	assign res.nack_seen = res_q.nack_seen;
	assign res.rejected  = res_q.rejected;

endmodule

FILE: rtl/i2cm_seq.sv
// Phase sequencer of the I2C master: command state, phase and bit counters, line levels.
// Depends on i2cm_pkg.
module i2cm_seq #(
	parameter int unsigned COUNT_WIDTH = i2cm_pkg::COUNT_W_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [2:0]                  op,
	input  logic [7:0]                  tx_byte,
	input  logic                        send_ack,
	input  logic                        sda_in,
	input  logic [i2cm_pkg::HP_W-1:0]   half_period,
	output i2cm_pkg::res_t              res_nxt
);

	localparam int unsigned HPW = i2cm_pkg::HP_W;

	i2cm_pkg::st_t st_q, st_d;
	logic [1:0]             ph_q, ph_d;
	logic [3:0]             bit_q, bit_d;
	logic [COUNT_WIDTH-1:0] tick_q, tick_d;
	logic [7:0]             shift_q, shift_d;
	logic                   scl_q, scl_d;
	logic                   sda_q, sda_d;
	logic                   ack_q, ack_d;
	logic                   want_q, want_d;
	logic [7:0]             rx_q, rx_d;

	logic [COUNT_WIDTH-1:0] hp_lim, hp_eff;
	logic                   valid_op, phase_end, last_ph, seq_end;
	logic [1:0]             last_ph_idx;
	logic [3:0]             bit_nx, last_bit;
	logic                   done, rej;
	logic [1:0]             lv;

	// clamp the hold to what the counter holds
	if (COUNT_WIDTH < HPW) begin : g_clamp
		assign hp_lim = (|half_period[HPW-1:COUNT_WIDTH]) ? '1
			: half_period[COUNT_WIDTH-1:0];
	end else if (COUNT_WIDTH == HPW) begin : g_same
		assign hp_lim = half_period;
	end else begin : g_wide
		assign hp_lim = {{(COUNT_WIDTH-HPW){1'b0}}, half_period};
	end
	assign hp_eff = (hp_lim == '0) ? COUNT_WIDTH'(1) : hp_lim;

	// line levels of one phase; {scl, sda}
	function automatic logic [1:0] levels(i2cm_pkg::st_t st, logic [1:0] ph, logic [3:0] b,
		logic [7:0] sh, logic wa, logic scl, logic sda);
		logic s_c;
		logic s_d;
		s_c = scl;
		s_d = sda;
		case (st)
			i2cm_pkg::ST_START: begin
				case (ph)
					2'd0:    s_d = 1'b1;
					2'd1:    begin s_c = 1'b1; s_d = 1'b1; end
					2'd2:    begin s_c = 1'b1; s_d = 1'b0; end
					default: begin s_c = 1'b0; s_d = 1'b0; end
				endcase
			end
			i2cm_pkg::ST_STOP: begin
				case (ph)
					2'd0:    s_c = 1'b0;
					2'd1:    begin s_c = 1'b0; s_d = 1'b0; end
					2'd2:    begin s_c = 1'b1; s_d = 1'b0; end
					default: begin s_c = 1'b1; s_d = 1'b1; end
				endcase
			end
			i2cm_pkg::ST_WRITE: begin
				s_c = (ph == 2'd1);
				if (b >= 4'd8 || (b == 4'd7 && ph == 2'd2))
					s_d = 1'b1;
				else
					s_d = |((sh << b[2:0]) & i2cm_pkg::BIT_MSB);
			end
			i2cm_pkg::ST_READ: begin
				if (b < 4'd8) begin
					s_c = (ph == 2'd0);
					s_d = 1'b1;
				end else begin
					s_c = (ph == 2'd1);
					s_d = ~wa;
				end
			end
			default: ;
		endcase
		return {s_c, s_d};
	endfunction

	assign valid_op  = (op == i2cm_pkg::OP_START) || (op == i2cm_pkg::OP_STOP)
		|| (op == i2cm_pkg::OP_WRITE) || (op == i2cm_pkg::OP_READ);
	assign phase_end = (tick_q >= hp_eff);

	always_comb begin
		case (st_q)
			i2cm_pkg::ST_START, i2cm_pkg::ST_STOP: last_ph_idx = 2'd3;
			i2cm_pkg::ST_WRITE: last_ph_idx = 2'd2;
			default:            last_ph_idx = (bit_q < 4'd8) ? 2'd1 : 2'd2;
		endcase
		last_bit = (st_q == i2cm_pkg::ST_WRITE || st_q == i2cm_pkg::ST_READ)
			? i2cm_pkg::LAST_DATA_BIT : 4'd0;
	end

	assign last_ph = (ph_q == last_ph_idx);
	assign bit_nx  = bit_q + {3'd0, last_ph};
	assign seq_end = phase_end && (bit_nx > last_bit);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			i2cm_pkg::ST_IDLE: begin
				if (valid_op)
					st_d = i2cm_pkg::st_t'(op);
			end
			i2cm_pkg::ST_START, i2cm_pkg::ST_STOP, i2cm_pkg::ST_WRITE,
			i2cm_pkg::ST_READ: begin
				if (seq_end)
					st_d = i2cm_pkg::ST_IDLE;
			end
			default: st_d = i2cm_pkg::ST_IDLE;
		endcase
	end

	// counters, shifter and line levels
	always_comb begin
		ph_d    = ph_q;
		bit_d   = bit_q;
		tick_d  = tick_q;
		shift_d = shift_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		want_d  = want_q;
		rx_d    = rx_q;
		done    = 1'b0;
		rej     = 1'b0;
		lv      = {scl_q, sda_q};
		if (st_q == i2cm_pkg::ST_IDLE) begin
			if (valid_op) begin
				ph_d   = 2'd0;
				bit_d  = 4'd0;
				tick_d = COUNT_WIDTH'(1);
				if (op == i2cm_pkg::OP_WRITE)
					shift_d = tx_byte;
				if (op == i2cm_pkg::OP_READ) begin
					shift_d = 8'd0;
					want_d  = send_ack;
				end
				lv    = levels(i2cm_pkg::st_t'(op), 2'd0, 4'd0, shift_d, want_d, scl_q, sda_q);
				scl_d = lv[1];
				sda_d = lv[0];
			end
		end else begin
			rej = valid_op;
			if (!phase_end) begin
				tick_d = tick_q + COUNT_WIDTH'(1);
			end else begin
				if (st_q == i2cm_pkg::ST_WRITE && bit_q == 4'd8 && ph_q == 2'd1)
					ack_d = sda_in;
				if (st_q == i2cm_pkg::ST_READ && bit_q < 4'd8 && ph_q == 2'd0)
					shift_d = {shift_q[6:0], sda_in};
				ph_d  = last_ph ? 2'd0 : ph_q + 2'd1;
				bit_d = bit_nx;
				if (seq_end) begin
					if (st_q == i2cm_pkg::ST_READ) begin
						rx_d  = shift_d;
						sda_d = 1'b1;
					end
					ph_d   = 2'd0;
					bit_d  = 4'd0;
					tick_d = '0;
					done   = 1'b1;
				end else begin
					lv     = levels(st_q, ph_d, bit_d, shift_d, want_q, scl_q, sda_q);
					scl_d  = lv[1];
					sda_d  = lv[0];
					tick_d = COUNT_WIDTH'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= i2cm_pkg::ST_IDLE;
			ph_q    <= 2'd0;
			bit_q   <= 4'd0;
			tick_q  <= '0;
			shift_q <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			want_q  <= 1'b0;
			rx_q    <= 8'd0;
		end else if (adv) begin
			st_q    <= st_d;
			ph_q    <= ph_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ack_q   <= ack_d;
			want_q  <= want_d;
			rx_q    <= rx_d;
		end
	end

	always_comb begin
		res_nxt.scl_level = scl_d;
		res_nxt.sda_level = sda_d;
		res_nxt.busy_res  = (st_d != i2cm_pkg::ST_IDLE);
		res_nxt.done_res  = done;
		res_nxt.rx_byte   = rx_d;
		res_nxt.nack_seen = ack_d;
		res_nxt.rejected  = rej;
	end

endmodule
